FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg - shared types and constants of the text console writer
// Screen geometry, action codes and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS       = 80;
	localparam int ROWS          = 25;
	localparam int CELLS         = COLUMNS * ROWS;
	localparam int ADDR_W        = $clog2(CELLS);
	localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

	// Field widths
	localparam int ACT_W  = 3;
	localparam int CHAR_W = 8;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int HW_W   = 11;
	localparam int CELL_W = 2 * CHAR_W;

	// Stream widths
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 40;

	// Character and attribute constants
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] RESET_COLOUR = 8'h07;
	localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_LF      = 8'h0A;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUT        = 3'd0,
		ACT_SET_CURSOR = 3'd1,
		ACT_CLEAR      = 3'd2,
		ACT_FILL       = 3'd3,
		ACT_SET_COLOUR = 3'd4,
		ACT_READ       = 3'd5
	} action_t;

	// Start point of the sweep counter
	typedef enum logic [1:0] {
		CNT_FIRST    = 2'd0,
		CNT_ROW1     = 2'd1,
		CNT_LAST_ROW = 2'd2
	} cnt_sel_t;

	typedef struct packed {
		logic     accept;
		logic     chk_range;
		logic     set_cursor;
		logic     new_line;
		logic     adv_col;
		logic     put_wr;
		logic     clr_hw;
		logic     set_colour;
		logic     rd_cell;
		logic     cnt_load;
		cnt_sel_t cnt_sel;
		logic     cnt_inc;
		logic     copy_rd;
		logic     copy_scroll;
		logic     blank_wr;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic last_col;
		logic last_row;
		logic in_range;
		logic cnt_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram - generic simple dual-port RAM
// One write port and one read port, read data registered and held while
// no read is issued.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath - cursor, colour, cell store and result register
// Executes the controller's commands: cursor moves, single-cell writes and
// reads, and the copy and blank sweeps over the cell store.
// ----------------------------------------------------------------------------
module tcw_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tcw_pkg::dp_cmd_t          cmd,
	output tcw_pkg::dp_stat_t         stat,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  logic [tcw_pkg::COL_W-1:0]  col,
	input  logic [tcw_pkg::ROW_W-1:0]  row,
	input  logic [tcw_pkg::CHAR_W-1:0] colour,
	input  logic                      m_tready,
	output logic                      m_tvalid,
	output logic                      status,
	output logic [tcw_pkg::COL_W-1:0]  cursor_col,
	output logic [tcw_pkg::ROW_W-1:0]  cursor_row,
	output logic [tcw_pkg::HW_W-1:0]   hw_cursor,
	output logic [tcw_pkg::CHAR_W-1:0] cell_char,
	output logic [tcw_pkg::CHAR_W-1:0] cell_attr
);

	import tcw_pkg::*;

	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [HW_W-1:0]   hw_q;
	logic [CHAR_W-1:0] colour_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              status_q;
	logic              rd_ok_q;

	logic              copy_vld_s1;
	logic              copy_fill_s1;
	logic [ADDR_W-1:0] copy_addr_s1;

	logic              out_vld_q;
	logic              out_status_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [HW_W-1:0]   out_hw_q;
	logic [CELL_W-1:0] out_cell_q;

	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] in_addr;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// Linear cell addresses of the cursor and of the requested cell
	assign cur_addr = ADDR_W'(cur_row_q) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_q);
	assign in_addr  = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);

	// Status toward the controller
	assign stat.last_col = (cur_col_q == COL_W'(COLUMNS - 1));
	assign stat.last_row = (cur_row_q == ROW_W'(ROWS - 1));
	assign stat.in_range = (col < COL_W'(COLUMNS)) && (row < ROW_W'(ROWS));
	assign stat.cnt_last = (cnt_q == ADDR_W'(CELLS - 1));
	assign stat.out_free = !out_vld_q || m_tready;

	// Cursor, hardware offset and colour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			hw_q      <= '0;
			colour_q  <= RESET_COLOUR;
		end else begin
			if (cmd.set_cursor) begin
				cur_col_q <= col;
				cur_row_q <= row;
			end else if (cmd.new_line) begin
				cur_col_q <= '0;
				if (stat.last_row) begin
					hw_q <= HW_W'(LAST_ROW_BASE);
				end else begin
					cur_row_q <= cur_row_q + 1'b1;
				end
			end else if (cmd.adv_col) begin
				cur_col_q <= cur_col_q + 1'b1;
				hw_q      <= HW_W'(cur_addr + 1'b1);
			end
			if (cmd.clr_hw) begin
				hw_q <= '0;
			end
			if (cmd.set_colour) begin
				colour_q <= colour;
			end
		end
	end

	// Per-item status and read qualifier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= 1'b0;
			rd_ok_q  <= 1'b0;
		end else if (cmd.accept) begin
			status_q <= cmd.chk_range && !stat.in_range;
			rd_ok_q  <= cmd.rd_cell;
		end
	end

	// Sweep counter; starts at zero for the clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_load) begin
			case (cmd.cnt_sel)
				CNT_FIRST:    cnt_q <= '0;
				CNT_ROW1:     cnt_q <= ADDR_W'(COLUMNS);
				CNT_LAST_ROW: cnt_q <= ADDR_W'(LAST_ROW_BASE);
				default:      cnt_q <= '0;
			endcase
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Copy write stage: write back in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_vld_s1 <= 1'b0;
		end else begin
			copy_vld_s1 <= cmd.copy_rd;
		end
	end

	always_ff @(posedge clk) begin
		copy_fill_s1 <= !cmd.copy_scroll;
		copy_addr_s1 <= cmd.copy_scroll ? cnt_q - ADDR_W'(COLUMNS) : cnt_q;
	end

	// Write port select: pending copy, blank sweep, then single character
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = {colour_q, char_code};
		if (copy_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = copy_addr_s1;
			ram_wdata = copy_fill_s1 ? {colour_q, ram_rdata[CHAR_W-1:0]} : ram_rdata;
		end else if (cmd.blank_wr) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q;
			ram_wdata = {colour_q, BLANK_CHAR};
		end else if (cmd.put_wr) begin
			ram_we    = 1'b1;
		end
	end

	// Read port select
	assign ram_re    = cmd.copy_rd || cmd.rd_cell;
	assign ram_raddr = cmd.copy_rd ? cnt_q : in_addr;

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Result register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_col_q    <= cur_col_q;
			out_row_q    <= cur_row_q;
			out_hw_q     <= hw_q;
			out_cell_q   <= rd_ok_q ? ram_rdata : '0;
		end
	end

	assign m_tvalid   = out_vld_q;
	assign status     = out_status_q;
	assign cursor_col = out_col_q;
	assign cursor_row = out_row_q;
	assign hw_cursor  = out_hw_q;
	assign cell_char  = out_cell_q[CHAR_W-1:0];
	assign cell_attr  = out_cell_q[CELL_W-1:CHAR_W];

endmodule

FILE: hdl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl - controller of the text console writer
// Decodes each action, sequences the sweeps over the cell store and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  tcw_pkg::action_t           action,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  tcw_pkg::dp_stat_t          stat,
	output tcw_pkg::dp_cmd_t           cmd
);

	import tcw_pkg::*;

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_COPY   = 6'b000100,
		ST_DRAIN  = 6'b001000,
		ST_BLANK  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   scroll_q;
	logic   scroll_d;

	assign s_tready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		scroll_d = scroll_q;
		case (state_q)
			ST_INIT: begin
				cmd.blank_wr = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (stat.cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_FINISH;
					case (action)
						ACT_PUT: begin
							if (char_code != CHAR_CR) begin
								if (char_code != CHAR_LF) begin
									cmd.put_wr = 1'b1;
								end
								if (char_code == CHAR_LF || stat.last_col) begin
									cmd.new_line = 1'b1;
									if (stat.last_row) begin
										cmd.cnt_load = 1'b1;
										cmd.cnt_sel  = CNT_ROW1;
										scroll_d     = 1'b1;
										state_d      = ST_COPY;
									end
								end else begin
									cmd.adv_col = 1'b1;
								end
							end
						end
						ACT_SET_CURSOR: begin
							cmd.chk_range  = 1'b1;
							cmd.set_cursor = stat.in_range;
						end
						ACT_CLEAR: begin
							cmd.clr_hw   = 1'b1;
							cmd.cnt_load = 1'b1;
							cmd.cnt_sel  = CNT_FIRST;
							state_d      = ST_BLANK;
						end
						ACT_FILL: begin
							cmd.set_colour = 1'b1;
							cmd.cnt_load   = 1'b1;
							cmd.cnt_sel    = CNT_FIRST;
							scroll_d       = 1'b0;
							state_d        = ST_COPY;
						end
						ACT_SET_COLOUR: begin
							cmd.set_colour = 1'b1;
						end
						ACT_READ: begin
							cmd.chk_range = 1'b1;
							cmd.rd_cell   = stat.in_range;
						end
						default: begin
						end
					endcase
				end
			end
			ST_COPY: begin
				cmd.copy_rd     = 1'b1;
				cmd.copy_scroll = scroll_q;
				cmd.cnt_inc     = 1'b1;
				if (stat.cnt_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last copy write completes here
				if (scroll_q) begin
					cmd.cnt_load = 1'b1;
					cmd.cnt_sel  = CNT_LAST_ROW;
					state_d      = ST_BLANK;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_BLANK: begin
				cmd.blank_wr = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (stat.cnt_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			scroll_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			scroll_q <= scroll_d;
		end
	end

endmodule

FILE: hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer - text console with cell store, cursor and colour
// Takes one action per beat and returns one result beat with status,
// cursor, hardware cursor offset and the bytes of a read cell.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                     Content
// s_*      in   tvalid tready tdata tuser   action; char, col, row, colour
// m_*      out  tvalid tready tdata tuser   status; cursor, hw cursor, cell
//
// Put char, set cursor, set colour, read cell and unused codes go straight from
// accept to the finish state. Clear, colour fill and a put char that scrolls
// sweep the whole store, one cell at a time through the single write port of
// the cell RAM.
// After reset a clearing pass over every cell fills the store with
// blanks; no beat is accepted until it ends.
// One item at a time; the next is accepted once the result is in the output
// register, which holds while m_tready is low.
// ----------------------------------------------------------------------------
module text_console_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// char_code[7:0], col[14:8], row[19:15], colour[27:20], zero pad
	input  logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
	// action[2:0]
	input  logic [tcw_pkg::ACT_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// cursor_col[6:0], cursor_row[11:7], hw_cursor[22:12],
	// cell_char[30:23], cell_attr[38:31], zero pad
	output logic [tcw_pkg::M_TDATA_W-1:0] m_tdata,
	// status[0]
	output logic [0:0]                    m_tuser
);

	import tcw_pkg::*;

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [CHAR_W-1:0] in_char;
	logic [COL_W-1:0]  in_col;
	logic [ROW_W-1:0]  in_row;
	logic [CHAR_W-1:0] in_colour;
	logic              out_status;
	logic [COL_W-1:0]  out_col;
	logic [ROW_W-1:0]  out_row;
	logic [HW_W-1:0]   out_hw;
	logic [CHAR_W-1:0] out_char;
	logic [CHAR_W-1:0] out_attr;

	// Unpack the input beat
	assign in_char   = s_tdata[7:0];
	assign in_col    = s_tdata[14:8];
	assign in_row    = s_tdata[19:15];
	assign in_colour = s_tdata[27:20];

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (action_t'(s_tuser)),
		.char_code(in_char),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.char_code (in_char),
		.col       (in_col),
		.row       (in_row),
		.colour    (in_colour),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.status    (out_status),
		.cursor_col(out_col),
		.cursor_row(out_row),
		.hw_cursor (out_hw),
		.cell_char (out_char),
		.cell_attr (out_attr)
	);

	// Pack the result beat
	assign m_tdata = {1'b0, out_attr, out_char, out_hw, out_row, out_col};
	assign m_tuser = out_status;

	// Reported cursor stays on screen
	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] < COL_W'(COLUMNS)) && (m_tdata[11:7] < ROW_W'(ROWS)))
		else $error("cursor off screen");

	// Hardware cursor offset stays inside the cell store
	a_hw_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[22:12] < HW_W'(CELLS)))
		else $error("hardware cursor outside cell store");

	// An error result carries no cell bytes
	a_err_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[38:23] == '0))
		else $error("cell bytes on error result");

	// One item at a time: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while busy");

endmodule

FILE: bench/text_console_writer_test.sv
// ----------------------------------------------------------------------------
// text_console_writer_test - self-checking bench for the text console writer
// Drives action beats on the input stream and compares every result beat
// against an in-bench console predictor. A short directed table covers range
// errors, carriage return, line feed, row-end wrap, both kinds of scroll,
// clear, colour fill and the spare action codes. A long random run follows
// with cursor moves biased toward the bottom row. Both stream sides idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module text_console_writer_test;
	import tcw_pkg::*;

	localparam int          RAND_CMDS       = 1225;
	localparam int          HOLD_OFF_CYCLES = 400;
	localparam int          STALL_LIMIT     = 20000;
	localparam int          DRAIN_CYCLES    = 50;
	localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
	localparam logic        ST_OK           = 1'b0;
	localparam logic        ST_RANGE        = 1'b1;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [CHAR_W-1:0] char_code;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [CHAR_W-1:0] colour;
	} console_cmd_t;

	typedef struct packed {
		logic              status;
		logic [COL_W-1:0]  cur_col;
		logic [ROW_W-1:0]  cur_row;
		logic [HW_W-1:0]   hw;
		logic [CHAR_W-1:0] cell_char;
		logic [CHAR_W-1:0] cell_attr;
	} console_reply_t;

	typedef struct packed {
		console_cmd_t   cmd;
		logic           typed;
		console_reply_t reply;
	} dir_row_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata  = '0;
	logic [ACT_W-1:0]       s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [0:0]             m_tuser;

	// Predicted screen contents and cursor state
	logic [CELL_W-1:0]      scr_cells [0:CELLS-1];
	int                     scr_col;
	int                     scr_row;
	int                     scr_hw;
	logic [CHAR_W-1:0]      scr_colour;

	console_reply_t         console_replies [$];
	dir_row_t               dir_table [$];

	bit                     no_gaps;
	bit                     hold_off_req;
	int                     fail_count;
	int                     beats_checked;
	int                     stall_cycles;
	int                     cmds_sent;
	int                     put_count;
	int                     scroll_count;
	int                     sweep_count;
	int                     read_count;
	int                     range_errs;

	text_console_writer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic console_cmd_t mk_cmd(input logic [ACT_W-1:0] a, input int ch,
			input int c, input int r, input int clr);
		console_cmd_t cmd;
		cmd.action    = a;
		cmd.char_code = CHAR_W'(ch);
		cmd.col       = COL_W'(c);
		cmd.row       = ROW_W'(r);
		cmd.colour    = CHAR_W'(clr);
		return cmd;
	endfunction

	function automatic console_reply_t mk_reply(input logic st, input int c, input int r,
			input int hw, input int ch, input int at);
		console_reply_t rep;
		rep.status    = st;
		rep.cur_col   = COL_W'(c);
		rep.cur_row   = ROW_W'(r);
		rep.hw        = HW_W'(hw);
		rep.cell_char = CHAR_W'(ch);
		rep.cell_attr = CHAR_W'(at);
		return rep;
	endfunction

	// Blank every cell with the current colour
	function automatic void scr_blank_all();
		for (int i = 0; i < CELLS; i++)
			scr_cells[i] = {scr_colour, BLANK_CHAR};
	endfunction

	// Return the cursor to column 0; scroll one row when past the bottom
	function automatic void scr_new_line();
		scr_col = 0;
		scr_row++;
		if (scr_row >= ROWS) begin
			scr_row = ROWS - 1;
			for (int i = 0; i + COLUMNS < CELLS; i++)
				scr_cells[i] = scr_cells[i + COLUMNS];
			for (int i = LAST_ROW_BASE; i < CELLS; i++)
				scr_cells[i] = {scr_colour, BLANK_CHAR};
			scr_hw = LAST_ROW_BASE;
			scroll_count++;
		end
	endfunction

	// Apply one command to the predicted console and return its result
	function automatic console_reply_t console_step(input console_cmd_t cmd);
		console_reply_t rep;
		bit             in_range;
		int             idx;
		rep      = '0;
		in_range = (int'(cmd.col) < COLUMNS) && (int'(cmd.row) < ROWS);
		case (cmd.action)
			ACT_PUT: begin
				put_count++;
				if (cmd.char_code == CHAR_LF) begin
					scr_new_line();
				end else if (cmd.char_code != CHAR_CR) begin
					scr_cells[scr_row * COLUMNS + scr_col] = {scr_colour, cmd.char_code};
					scr_col++;
					if (scr_col < COLUMNS)
						scr_hw = scr_row * COLUMNS + scr_col;
					else
						scr_new_line();
				end
			end
			ACT_SET_CURSOR: begin
				if (in_range) begin
					scr_col = cmd.col;
					scr_row = cmd.row;
				end else begin
					rep.status = ST_RANGE;
				end
			end
			ACT_CLEAR: begin
				scr_blank_all();
				scr_hw = 0;
				sweep_count++;
			end
			ACT_FILL: begin
				scr_colour = cmd.colour;
				for (int i = 0; i < CELLS; i++)
					scr_cells[i][CELL_W-1:CHAR_W] = scr_colour;
				sweep_count++;
			end
			ACT_SET_COLOUR: scr_colour = cmd.colour;
			ACT_READ: begin
				read_count++;
				if (in_range) begin
					idx           = cmd.row * COLUMNS + cmd.col;
					rep.cell_char = scr_cells[idx][CHAR_W-1:0];
					rep.cell_attr = scr_cells[idx][CELL_W-1:CHAR_W];
				end else begin
					rep.status = ST_RANGE;
				end
			end
			default: ;
		endcase
		if (rep.status == ST_RANGE)
			range_errs++;
		rep.cur_col = COL_W'(scr_col);
		rep.cur_row = ROW_W'(scr_row);
		rep.hw      = HW_W'(scr_hw);
		return rep;
	endfunction

	// Draw a random command, biased toward deep console behavior
	function automatic console_cmd_t rand_cmd();
		console_cmd_t cmd;
		int           pick;
		int           sub;
		cmd  = mk_cmd(ACT_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom);
		pick = $urandom_range(0, 99);
		sub  = $urandom_range(0, 99);
		if (pick < 58) begin
			cmd.action = ACT_PUT;
			if (sub < 6)
				cmd.char_code = CHAR_LF;
			else if (sub < 9)
				cmd.char_code = CHAR_CR;
			else if (sub < 70)
				cmd.char_code = CHAR_W'($urandom_range(8'h21, 8'h7E));
		end else if (pick < 66) begin
			cmd.action = ACT_SET_CURSOR;
			if (sub < 5) begin
				cmd.col = COL_W'($urandom_range(COLUMNS, 127));
			end else if (sub < 10) begin
				cmd.row = ROW_W'($urandom_range(ROWS, 31));
			end else begin
				cmd.col = COL_W'($urandom_range(0, COLUMNS - 1));
				cmd.row = (sub < 50) ? ROW_W'(ROWS - 1) : ROW_W'($urandom_range(0, ROWS - 1));
			end
		end else if (pick < 68) begin
			cmd.action = ACT_CLEAR;
		end else if (pick < 70) begin
			cmd.action = ACT_FILL;
		end else if (pick < 76) begin
			cmd.action = ACT_SET_COLOUR;
		end else if (pick < 94) begin
			cmd.action = ACT_READ;
			if (sub < 4) begin
				cmd.col = COL_W'($urandom_range(COLUMNS, 127));
			end else if (sub < 8) begin
				cmd.row = ROW_W'($urandom_range(ROWS, 31));
			end else if (sub < 60) begin
				// Read back cells just written around the cursor
				cmd.row = ROW_W'((scr_row > 0 && sub < 30) ? scr_row - 1 : scr_row);
				cmd.col = COL_W'(scr_col > 0 ? $urandom_range(0, scr_col) : 0);
			end else begin
				cmd.col = COL_W'($urandom_range(0, COLUMNS - 1));
				cmd.row = ROW_W'($urandom_range(0, ROWS - 1));
			end
		end else begin
			cmd.action = (sub < 50) ? ACT_SPARE_6 : ACT_SPARE_7;
		end
		return cmd;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("result field %s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic dir_row(input console_cmd_t cmd, input logic typed,
			input console_reply_t reply);
		dir_table.push_back({cmd, typed, reply});
	endtask

	// Offer one command beat and record its expected result on acceptance
	task automatic offer_cmd(input console_cmd_t cmd, input logic typed,
			input console_reply_t typed_reply);
		console_reply_t want;
		if (!no_gaps && $urandom_range(0, 99) < 14) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd.action;
		s_tdata  <= S_TDATA_W'({cmd.colour, cmd.row, cmd.col, cmd.char_code});
		do @(posedge clk); while (!(s_tvalid && s_tready));
		want = console_step(cmd);
		console_replies.push_back(typed ? typed_reply : want);
		cmds_sent++;
	endtask

	// Result side: random backpressure with one long hold-off on request
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			m_tready <= no_gaps || ($urandom_range(0, 99) >= 14);
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin : result_check
		console_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beats_checked++;
			if (console_replies.size() == 0) begin
				$error("result beat with no command outstanding");
				fail_count++;
			end else begin
				want = console_replies.pop_front();
				check_field("status", want.status, m_tuser[0]);
				check_field("cursor_col", want.cur_col, m_tdata[6:0]);
				check_field("cursor_row", want.cur_row, m_tdata[11:7]);
				check_field("hw_cursor", want.hw, m_tdata[22:12]);
				check_field("cell_char", want.cell_char, m_tdata[30:23]);
				check_field("cell_attr", want.cell_attr, m_tdata[38:31]);
			end
		end
	end

	// Abort when no beat moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("text_console_writer verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : stimulus
		dir_row_t row;
		scr_colour = RESET_COLOUR;
		scr_blank_all();
		scr_col = 0;
		scr_row = 0;
		scr_hw  = 0;
		no_gaps = 1'b0;

		// Range errors and the reset screen first, while nothing has moved
		dir_row(mk_cmd(ACT_READ, 0, 0, 0, 0), 1'b1,
			mk_reply(ST_OK, 0, 0, 0, BLANK_CHAR, RESET_COLOUR));
		dir_row(mk_cmd(ACT_SET_CURSOR, 0, COLUMNS, 0, 0), 1'b1,
			mk_reply(ST_RANGE, 0, 0, 0, 0, 0));
		dir_row(mk_cmd(ACT_READ, 0, 0, ROWS, 0), 1'b1, mk_reply(ST_RANGE, 0, 0, 0, 0, 0));
		dir_row(mk_cmd(ACT_READ, 0, 127, 31, 0), 1'b1, mk_reply(ST_RANGE, 0, 0, 0, 0, 0));
		dir_row(mk_cmd(ACT_SET_CURSOR, 0, 127, 31, 0), 1'b1,
			mk_reply(ST_RANGE, 0, 0, 0, 0, 0));
		// Printing, carriage return, byte extremes, colour, line feed
		dir_row(mk_cmd(ACT_PUT, 8'h41, 0, 0, 0), 1'b0, '0);
		dir_row(mk_cmd(ACT_PUT, CHAR_CR, 0, 0, 0), 1'b0, '0);
		dir_row(mk_cmd(ACT_PUT, 8'hFF, 0, 0, 0), 1'b0, '0);
		dir_row(mk_cmd(ACT_PUT, 8'h00, 0, 0, 0), 1'b0, '0);
		dir_row(mk_cmd(ACT_SET_COLOUR, 0, 0, 0, 8'hFF), 1'b0, '0);
		dir_row(mk_cmd(ACT_PUT, CHAR_LF, 0, 0, 0), 1'b0, '0);
		// Wrap at the last cell scrolls; check the moved and the blanked rows
		dir_row(mk_cmd(ACT_SET_CURSOR, 0, COLUMNS - 1, ROWS - 1, 0), 1'b0, '0);
		dir_row(mk_cmd(ACT_PUT, 8'h5A, 0, 0, 0), 1'b0, '0);
		dir_row(mk_cmd(ACT_READ, 0, COLUMNS - 1, ROWS - 2, 0), 1'b0, '0);
		dir_row(mk_cmd(ACT_READ, 0, 0, ROWS - 1, 0), 1'b0, '0);
		// Line feed on the bottom row scrolls too
		dir_row(mk_cmd(ACT_SET_CURSOR, 0, 0, ROWS - 1, 0), 1'b0, '0);
		dir_row(mk_cmd(ACT_PUT, CHAR_LF, 0, 0, 0), 1'b0, '0);
		// Wrap at a row end without scrolling leaves the hw cursor
		dir_row(mk_cmd(ACT_SET_CURSOR, 0, COLUMNS - 1, 0, 0), 1'b0, '0);
		dir_row(mk_cmd(ACT_PUT, 8'h80, 0, 0, 0), 1'b0, '0);
		dir_row(mk_cmd(ACT_READ, 0, COLUMNS - 1, 0, 0), 1'b0, '0);
		// Whole-screen sweeps and the spare codes
		dir_row(mk_cmd(ACT_FILL, 0, 0, 0, 8'h00), 1'b0, '0);
		dir_row(mk_cmd(ACT_CLEAR, 0, 0, 0, 0), 1'b0, '0);
		dir_row(mk_cmd(ACT_READ, 0, COLUMNS - 1, ROWS - 1, 0), 1'b0, '0);
		dir_row(mk_cmd(ACT_SPARE_6, 8'hFF, 127, 31, 8'hFF), 1'b0, '0);
		dir_row(mk_cmd(ACT_SPARE_7, 0, 0, 0, 0), 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_table[i]) begin
			row = dir_table[i];
			offer_cmd(row.cmd, row.typed, row.reply);
		end

		// Random run: a burst against a held-off sink, later a gap-free stretch
		hold_off_req = 1'b1;
		for (int i = 0; i < RAND_CMDS; i++) begin
			no_gaps = (i < 40) || (i >= 500 && i < 700);
			offer_cmd(rand_cmd(), 1'b0, '0);
		end
		@(posedge clk);
		s_tvalid <= 1'b0;
		no_gaps = 1'b0;

		while (console_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands, checked %0d result beats (%0d range errors).",
			cmds_sent, beats_checked, range_errs);
		$display("Covered %0d puts, %0d scrolls, %0d clear or fill sweeps, %0d reads.",
			put_count, scroll_count, sweep_count, read_count);
		if (fail_count == 0)
			$display("text_console_writer verification clean");
		else
			$display("text_console_writer verification failed");
		$finish;
	end

endmodule
